/* hw/rtl/vd_pkg.sv */
// ----------------------------------------------------------------------------
// vd_pkg
// Shared types and constants of the vertex dedup index builder.
// ----------------------------------------------------------------------------
package vd_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int COMP_W        = 32;
    localparam int NUM_COMP      = 8;
    localparam int KEY_W         = COMP_W * NUM_COMP;
    localparam int VIDX_W        = 10;

    // one classified corner, as queued between front and back
    typedef struct packed {
        logic             mesh_start;
        logic             has_nan;
        logic [KEY_W-1:0] key;
    } item_t;

    // back part states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_RESULT = 3'b100
    } back_state_t;

    // true when a single-precision bit pattern is a NaN
    function automatic logic comp_is_nan(input logic [COMP_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // fold -0 onto +0 so that plain equality matches float equality
    function automatic logic [COMP_W-1:0] comp_norm(input logic [COMP_W-1:0] b);
        return (b[30:0] == 31'd0) ? '0 : b;
    endfunction

endpackage

/* hw/rtl/vd_front.sv */
// ----------------------------------------------------------------------------
// vd_front
// Accepts corners, flags NaN components, normalizes signed zeros and holds
// the classified items in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module vd_front import vd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
    input  logic             s_tuser,   // mesh_start
    output logic             item_valid,
    output item_t            item,
    input  logic             item_pop
);

    item_t       fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       cls;
    logic        push;
    logic        nan_any;

    // classify the incoming corner
    always_comb begin
        nan_any = 1'b0;
        cls.key = '0;
        for (int i = 0; i < NUM_COMP; i++) begin
            nan_any = nan_any | comp_is_nan(s_tdata[i*COMP_W +: COMP_W]);
            cls.key[i*COMP_W +: COMP_W] = comp_norm(s_tdata[i*COMP_W +: COMP_W]);
        end
        cls.has_nan    = nan_any;
        cls.mesh_start = s_tuser;
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = fifo_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* hw/rtl/vd_back.sv */
// ----------------------------------------------------------------------------
// vd_back
// Scans the stored distinct tuples for a match, inserts unseen tuples at
// the fill count while the table has room and drives the result register.
// ----------------------------------------------------------------------------
module vd_back import vd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  item_t             item,
    output logic              item_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,  // vertex_index, zero pad
    output logic [1:0]        m_tuser   // is_new, table_full
);

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [KEY_W-1:0]   key_reg;
    logic               nan_reg;
    logic               rd_v_reg, rd_v_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [KEY_W:0]     rd_data_reg;
    logic               res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic               out_v_reg, out_v_next;
    logic [VIDX_W-1:0]  out_idx_reg;
    logic               out_new_reg;
    logic               out_full_reg;
    logic               out_free;
    logic               issue;
    logic               hit;
    logic               last;
    logic               insert;
    logic               finish;
    logic               full;

    logic [KEY_W:0]     key_mem [TABLE_ENTRIES];

    assign out_free = !out_v_reg || m_tready;
    assign full     = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign issue    = (state_reg == S_SCAN) && (scan_reg < count_reg);
    assign hit      = rd_v_reg && (rd_data_reg == {1'b0, key_reg});
    assign last     = rd_v_reg && ({1'b0, rd_idx_reg} == count_reg - CNT_W'(1));
    assign finish   = (state_reg == S_RESULT) && out_free;
    assign insert   = finish && !res_hit_reg && !full;
    assign item_pop = (state_reg == S_IDLE) && item_valid;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        rd_v_next    = 1'b0;
        res_hit_next = res_hit_reg;
        res_idx_next = res_idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    scan_next    = '0;
                    res_hit_next = 1'b0;
                    if (item.mesh_start) begin
                        count_next = '0;
                    end
                    if (item.has_nan || item.mesh_start || count_reg == '0) begin
                        state_next = S_RESULT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    res_hit_next = 1'b1;
                    res_idx_next = rd_idx_reg;
                    state_next   = S_RESULT;
                end else if (last) begin
                    state_next   = S_RESULT;
                end else begin
                    rd_v_next = issue;
                    if (issue) begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (insert) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_v_reg  <= rd_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        res_hit_reg <= res_hit_next;
        res_idx_reg <= res_idx_next;
        rd_idx_reg  <= scan_reg[IDX_W-1:0];
        if (item_pop) begin
            key_reg <= item.key;
            nan_reg <= item.has_nan;
        end
    end

    // tuple store, one entry per compact index
    always_ff @(posedge aclk) begin
        if (insert) begin
            key_mem[count_reg[IDX_W-1:0]] <= {nan_reg, key_reg};
        end
        rd_data_reg <= key_mem[scan_reg[IDX_W-1:0]];
    end

    // result register
    always_comb begin
        out_v_next = out_v_reg;
        if (finish) begin
            out_v_next = 1'b1;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            if (res_hit_reg) begin
                out_idx_reg  <= VIDX_W'(res_idx_reg);
                out_new_reg  <= 1'b0;
                out_full_reg <= 1'b0;
            end else if (full) begin
                out_idx_reg  <= '0;
                out_new_reg  <= 1'b0;
                out_full_reg <= 1'b1;
            end else begin
                out_idx_reg  <= VIDX_W'(count_reg);
                out_new_reg  <= 1'b1;
                out_full_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(16-VIDX_W){1'b0}}, out_idx_reg};
    assign m_tuser  = {out_full_reg, out_new_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == S_SCAN))
        else $error("table read outside scan");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> !(out_new_reg && out_full_reg))
        else $error("new and full both set");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance fill count");
`endif

endmodule

/* hw/rtl/vertex_dedup_index_builder.sv */
// Timing: a corner scans the stored tuples in order until a match (all stored
// tuples when unseen); NaN corners, mesh starts and corners on an empty table
// skip the scan. One tuple is compared per cycle from the single read port of
// the tuple store, which sets the rate.
// Reset clears the fill count and handshake state; the store is not cleared.
// ----------------------------------------------------------------------------
// vertex_dedup_index_builder
// Vertex welding: maps each corner's attribute tuple to a compact index.
// ----------------------------------------------------------------------------
module vertex_dedup_index_builder import vd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
    input  logic             s_tuser,   // mesh_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // vertex_index, zero pad
    output logic [1:0]       m_tuser    // is_new, table_full
);

    logic  item_valid;
    item_t item;
    logic  item_pop;

    vd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    vd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* tb/vd_checker.sv */
// ----------------------------------------------------------------------------
// vd_checker
// Watches both channels of the vertex dedup index builder, keeps its own
// tuple table, predicts each corner's index and flags, compares in order.
// ----------------------------------------------------------------------------
module vd_checker import vd_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [KEY_W-1:0] s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,
    input  logic [1:0]       m_tuser,
    output int               err_count,
    output int               pending
);

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic              is_new;
        logic              full;
    } weld_t;

    logic [KEY_W-1:0] tuples [TABLE_ENTRIES];
    int               n_distinct;
    weld_t            weld_q [$];

    function automatic logic is_nan32(input logic [31:0] b);
        return b[30:23] == 8'hFF && b[22:0] != 0;
    endfunction

    function automatic logic same_comp(input logic [31:0] a, input logic [31:0] b);
        if (is_nan32(a) || is_nan32(b)) return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
        return a == b;
    endfunction

    function automatic logic same_tuple(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
        for (int c = 0; c < NUM_COMP; c++)
            if (!same_comp(a[c*32 +: 32], b[c*32 +: 32])) return 1'b0;
        return 1'b1;
    endfunction

    // look up or insert one corner, return its expected result
    function automatic weld_t weld_corner(input logic start, input logic [KEY_W-1:0] key);
        weld_t r;
        if (start) n_distinct = 0;
        for (int k = 0; k < n_distinct; k++)
            if (same_tuple(tuples[k], key)) begin
                r.vidx = k[VIDX_W-1:0]; r.is_new = 0; r.full = 0;
                return r;
            end
        if (n_distinct >= TABLE_ENTRIES) begin
            r.vidx = '0; r.is_new = 0; r.full = 1;
            return r;
        end
        tuples[n_distinct] = key;
        r.vidx = n_distinct[VIDX_W-1:0]; r.is_new = 1; r.full = 0;
        n_distinct++;
        return r;
    endfunction

    // predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        weld_t want;
        if (!aresetn) begin
            n_distinct = 0;
            err_count  = 0;
        end else begin
            if (s_tvalid && s_tready) weld_q = {weld_q, weld_corner(s_tuser, s_tdata)};
            if (m_tvalid && m_tready) begin
                if (weld_q.size() == 0) begin
                    $error("unexpected result transfer");
                    err_count++;
                end else begin
                    want = weld_q.pop_front();
                    if (m_tdata[VIDX_W-1:0] != want.vidx) begin
                        $error("vertex_index expected %0d got %0d", want.vidx,
                               m_tdata[VIDX_W-1:0]);
                        err_count++;
                    end
                    if (m_tuser[0] != want.is_new) begin
                        $error("is_new expected %0d got %0d", want.is_new, m_tuser[0]);
                        err_count++;
                    end
                    if (m_tuser[1] != want.full) begin
                        $error("table_full expected %0d got %0d", want.full, m_tuser[1]);
                        err_count++;
                    end
                end
            end
        end
        pending = weld_q.size();
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the vertex dedup index builder: directed float corner cases,
// a table fill to capacity, then meshes of reused and fresh corners under varying backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    import vd_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [KEY_W-1:0] s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [15:0]      m_tdata;
    logic [1:0]       m_tuser;
    int               err_count;
    int               pending;
    int               send_idle;
    int               recv_stall;

    localparam logic [31:0] F_ONE  = 32'h3F80_0000;
    localparam logic [31:0] F_NZERO = 32'h8000_0000;
    localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] F_INF  = 32'h7F80_0000;

    vertex_dedup_index_builder DUT (.*);

    vd_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stalls at the current rate
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    // one corner transfer, with random sender idling first
    task automatic send_corner(input logic start, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= start; s_tdata <= key;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        logic [KEY_W-1:0] k;
        for (int c = 0; c < NUM_COMP; c++) begin
            case ($urandom_range(7))
                0: k[c*32 +: 32] = 0;
                1: k[c*32 +: 32] = F_NZERO;
                2: k[c*32 +: 32] = F_QNAN | $urandom_range(1);
                3: k[c*32 +: 32] = F_ONE;
                default: k[c*32 +: 32] = $urandom;
            endcase
        end
        return k;
    endfunction

    // flip the sign of every zero component
    function automatic logic [KEY_W-1:0] flip_zeros(input logic [KEY_W-1:0] k);
        for (int c = 0; c < NUM_COMP; c++)
            if (k[c*32 +: 31] == 0) k[c*32 + 31] = ~k[c*32 + 31];
        return k;
    endfunction

    initial begin
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] k;
        int               mesh_len;
        s_tvalid = 0; s_tdata = 0; s_tuser = 0; m_tready = 0;
        send_idle = 0; recv_stall = 0;
        aresetn = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // signed zeros, NaN, infinity, all-ones bits, immediate reuse
        send_corner(1, '0);
        send_corner(0, {NUM_COMP{F_NZERO}});
        send_corner(0, {NUM_COMP{32'hFFFF_FFFF}});
        send_corner(0, {NUM_COMP{32'hFFFF_FFFF}});
        send_corner(0, {NUM_COMP{F_QNAN}});
        send_corner(0, {NUM_COMP{F_QNAN}});
        send_corner(0, {NUM_COMP{F_INF}});
        send_corner(0, {NUM_COMP{F_INF | F_NZERO}});
        send_corner(0, {NUM_COMP{F_INF}});
        send_corner(0, {{7{32'h0}}, F_NZERO});
        send_corner(0, {F_ONE, {7{32'h0}}});
        send_corner(0, {NUM_COMP{32'h5555_5555}});
        send_corner(0, {NUM_COMP{32'hAAAA_AAAA}});
        send_corner(1, {NUM_COMP{32'hFFFF_FFFF}});
        send_corner(0, '0);

        // fill the table to capacity, then probe it full
        send_corner(1, '0);
        for (int n = 1; n < TABLE_ENTRIES; n++) send_corner(0, KEY_W'(n));
        send_corner(0, {NUM_COMP{F_ONE}});
        send_corner(0, {NUM_COMP{F_QNAN}});
        send_corner(0, KEY_W'(TABLE_ENTRIES - 1));
        send_corner(0, {NUM_COMP{F_NZERO}});
        drain();

        // random meshes: mostly reused corners, some fresh, some noise
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 70; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 70; end
                default: begin send_idle = 10; recv_stall = 10; end
            endcase
            for (int m = 0; m < 2; m++) begin
                mesh_len = $urandom_range(6, 12);
                pool.delete();
                for (int n = 0; n < mesh_len; n++) begin
                    if (pool.size() > 0 && $urandom_range(99) < 60) begin
                        k = pool[$urandom_range(pool.size() - 1)];
                        if ($urandom_range(3) == 0) k = flip_zeros(k);
                    end else begin
                        k = rand_key();
                        pool = {pool, k};
                    end
                    send_corner(n == 0, k);
                end
            end
            // pause until every result is back
            drain();
        end

        send_idle = 0; recv_stall = 0;
        wait (pending == 0);
        repeat (2100) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
